/* hw/rtl/epdc_pkg.sv */
// ----------------------------------------------------------------------------
// Exponential PDF/CDF package
// Shared widths, constants and record types of the exponential evaluator.
// ----------------------------------------------------------------------------
package epdc_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int EXP_FB    = 30;
	localparam int PROD_W    = 2 * DATA_W - 1;
	localparam int CAP_LOG2  = 6;
	localparam int T_W       = EXP_FB + CAP_LOG2;
	localparam int K_W       = 7;
	localparam int TERMS     = 13;
	localparam int SH_R      = (2 * FRAC_BITS > EXP_FB) ? 2 * FRAC_BITS - EXP_FB : 0;
	localparam int SH_L      = (2 * FRAC_BITS < EXP_FB) ? EXP_FB - 2 * FRAC_BITS : 0;

	localparam logic [EXP_FB-1:0] LN2_Q30 = 30'd744261118;

	localparam int RECIP_SH = 50;
	localparam int T_DROP   = 10;
	localparam int RECIP_W  = 21;
	localparam logic [63:0] RECIP = (64'd1 << RECIP_SH) / 64'(LN2_Q30);
	localparam logic [63:0] K_MAX = (64'd1 << T_W) / 64'(LN2_Q30);

	localparam logic OP_PDF     = 1'b0;
	localparam logic OP_CDF     = 1'b1;
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_NEG = 1'b1;

	localparam int LATENCY = 3 + 3 * TERMS + 2;

	typedef struct packed {
		logic valid;
		logic op;
		logic neg;
		logic under;
		logic last;
	} epdc_ctl_t;

	typedef struct packed {
		epdc_ctl_t         ctl;
		logic [K_W-1:0]    k;
		logic [EXP_FB-1:0] rem;
		logic [EXP_FB+1:0] sum;
	} epdc_rec_t;

endpackage

/* hw/rtl/epdc_front.sv */
// ----------------------------------------------------------------------------
// Exponential front end
// Product of rate and sample, underflow test and reduction modulo ln2.
// ----------------------------------------------------------------------------
module epdc_front import epdc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic              operation,
	input  logic [DATA_W-1:0] sample,
	input  logic              last_sample,
	input  logic [DATA_W-1:0] rate,
	output epdc_rec_t         rec
);

	epdc_ctl_t                   ctl_s1, ctl_s2;
	logic [PROD_W-1:0]           p_s1;
	logic [T_W-1:0]              t_s2;
	logic [K_W-1:0]              k_s2;
	logic [T_W-1:0]              t_w;
	logic [T_W-T_DROP+RECIP_W-1:0] kprod_w;
	logic [T_W:0]                kl_w;
	logic [T_W-1:0]              rem0_w;
	logic                        fix_w;

	assign t_w     = T_W'((p_s1 >> SH_R) << SH_L);
	assign kprod_w = t_w[T_W-1:T_DROP] * RECIP[RECIP_W-1:0];
	assign kl_w    = (T_W+1)'(k_s2) * (T_W+1)'(LN2_Q30);
	assign rem0_w  = t_s2 - kl_w[T_W-1:0];
	assign fix_w   = rem0_w >= T_W'(LN2_Q30);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1.valid    <= 1'b0;
			ctl_s2.valid    <= 1'b0;
			rec.ctl.valid   <= 1'b0;
		end else if (en) begin
			ctl_s1.valid <= in_valid;
			ctl_s1.op    <= operation;
			ctl_s1.neg   <= sample[DATA_W-1];
			ctl_s1.under <= 1'b0;
			ctl_s1.last  <= last_sample;
			p_s1         <= PROD_W'(rate) * PROD_W'(sample[DATA_W-2:0]);

			ctl_s2 <= '{valid: ctl_s1.valid, op: ctl_s1.op, neg: ctl_s1.neg,
				under: |p_s1[PROD_W-1:2*FRAC_BITS+CAP_LOG2], last: ctl_s1.last};
			t_s2         <= t_w;
			k_s2         <= kprod_w[RECIP_SH-T_DROP +: K_W];

			rec.ctl <= ctl_s2;
			rec.k   <= fix_w ? k_s2 + K_W'(1) : k_s2;
			rec.rem <= fix_w ? EXP_FB'(rem0_w - T_W'(LN2_Q30)) : EXP_FB'(rem0_w);
			rec.sum <= (EXP_FB+2)'(1) << EXP_FB;
		end
	end

endmodule

/* hw/rtl/epdc_series.sv */
// ----------------------------------------------------------------------------
// Exponential series pipeline
// Alternating Taylor series of exp(-rem), three stages per term.
// ----------------------------------------------------------------------------
module epdc_series import epdc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  epdc_rec_t rec_in,
	output epdc_rec_t rec_out
);

	epdc_rec_t         rec_c  [0:TERMS];
	logic [EXP_FB:0]   term_c [0:TERMS];

	assign rec_c[0]  = rec_in;
	assign term_c[0] = (EXP_FB+1)'(1) << EXP_FB;
	assign rec_out   = rec_c[TERMS];

	for (genvar n = 1; n <= TERMS; n++) begin : g_term
		localparam int unsigned N = n;
		localparam logic [63:0] M64 = (64'd1 << 32) / 64'(N);

		epdc_rec_t         rec_a, rec_b, rec_o;
		logic [2*EXP_FB:0] prod_a;
		logic [EXP_FB:0]   a_b;
		logic [63:0]       qe_b;
		logic [EXP_FB:0]   term_o;
		logic [EXP_FB:0]   q_w;
		logic [EXP_FB:0]   r_w;
		logic [EXP_FB:0]   qf_w;
		logic [EXP_FB+1:0] sum_w;

		assign q_w   = qe_b[32 +: EXP_FB+1];
		assign r_w   = a_b - q_w * (EXP_FB+1)'(N);
		assign qf_w  = (r_w >= (EXP_FB+1)'(N)) ? q_w + (EXP_FB+1)'(1) : q_w;
		assign sum_w = (N % 2 == 1) ? rec_b.sum - (EXP_FB+2)'(qf_w)
			: rec_b.sum + (EXP_FB+2)'(qf_w);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rec_a.ctl.valid <= 1'b0;
				rec_b.ctl.valid <= 1'b0;
				rec_o.ctl.valid <= 1'b0;
			end else if (en) begin
				rec_a  <= rec_c[n-1];
				prod_a <= (2*EXP_FB+1)'(term_c[n-1]) * (2*EXP_FB+1)'(rec_c[n-1].rem);

				rec_b <= rec_a;
				a_b   <= prod_a[EXP_FB +: EXP_FB+1];
				qe_b  <= 64'(prod_a[EXP_FB +: EXP_FB+1]) * M64;

				rec_o  <= '{ctl: rec_b.ctl, k: rec_b.k, rem: rec_b.rem, sum: sum_w};
				term_o <= qf_w;
			end
		end

		assign rec_c[n]  = rec_o;
		assign term_c[n] = term_o;
	end

endmodule

/* hw/rtl/epdc_back.sv */
// ----------------------------------------------------------------------------
// Exponential back end
// Scales the series result by 2^-k and forms density or cumulative value.
// ----------------------------------------------------------------------------
module epdc_back import epdc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  epdc_rec_t         rec,
	input  logic [DATA_W-1:0] rate,
	output logic              out_valid,
	output logic [DATA_W-1:0] value,
	output logic              status,
	output logic              last_result
);

	function automatic logic [63:0] round_shift(input logic [63:0] v, input logic [7:0] s);
		logic [63:0] r;
		if (s >= 8'd63) begin
			r = 64'd0;
		end else if (s == 8'd0) begin
			r = v;
		end else begin
			r = (v + (64'd1 << (s - 8'd1))) >> s;
		end
		return r;
	endfunction

	epdc_ctl_t         ctl_d1;
	logic [PROD_W-1:0] prod_d1;
	logic [63:0]       e_d1;
	logic [K_W-1:0]    k_d1;
	logic [63:0]       pdf_w;
	logic [63:0]       ex_w;
	logic [DATA_W-1:0] val_w;
	logic [63:0]       one_w;

	assign one_w = 64'd1 << FRAC_BITS;
	assign pdf_w = round_shift(64'(prod_d1), 8'(EXP_FB) + 8'(k_d1));
	assign ex_w  = round_shift(e_d1, 8'(EXP_FB - FRAC_BITS) + 8'(k_d1));

	always_comb begin
		priority if (ctl_d1.neg) begin
			val_w = '0;
		end else if (ctl_d1.under) begin
			val_w = (ctl_d1.op == OP_CDF) ? DATA_W'(one_w) : '0;
		end else if (ctl_d1.op == OP_CDF) begin
			val_w = (ex_w >= one_w) ? '0 : DATA_W'(one_w - ex_w);
		end else begin
			val_w = (pdf_w[63:DATA_W] != '0) ? '1 : pdf_w[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_d1.valid <= 1'b0;
			out_valid    <= 1'b0;
		end else if (en) begin
			ctl_d1  <= rec.ctl;
			prod_d1 <= PROD_W'(rate) * PROD_W'(rec.sum[EXP_FB:0]);
			e_d1    <= 64'(rec.sum);
			k_d1    <= rec.k;

			out_valid   <= ctl_d1.valid;
			value       <= val_w;
			status      <= ctl_d1.neg ? STATUS_NEG : STATUS_OK;
			last_result <= ctl_d1.last;
		end
	end

endmodule

/* hw/rtl/exponential_pdf_cdf_unit.sv */
// ----------------------------------------------------------------------------
// Exponential PDF/CDF unit
// Evaluates rate*exp(-rate*x) or 1-exp(-rate*x) in Q16.16 for a stream of
// samples. The user must load the rate register through rate_wr_en and
// rate_wr_data only while no transfer is in flight, which the unit does not
// enforce; reset loads a rate of 1.0. Input transfers carry operation, sample
// and last_sample; output transfers carry value, status and last_result, one
// per input, in order. A negative sample gives value zero with status one.
// The unit is a 44-stage pipeline, and one sample is taken every cycle while
// the receiver does not stall a valid result. Most of the depth comes from
// the thirteen-term series, three stages per term.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall rises in the same cycle, so nothing is lost or repeated.
// Reset clears all valid bits, out_valid among them, but no data outputs.
// ----------------------------------------------------------------------------
module exponential_pdf_cdf_unit import epdc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rate_wr_en,
	input  logic [DATA_W-1:0] rate_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              operation,
	input  logic [DATA_W-1:0] sample,
	input  logic              last_sample,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DATA_W-1:0] value,
	output logic              status,
	output logic              last_result
);

	logic [DATA_W-1:0] rate_q;
	logic              en;
	epdc_rec_t         rec_f, rec_s;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= DATA_W'(1) << FRAC_BITS;
		end else if (rate_wr_en) begin
			rate_q <= rate_wr_data;
		end
	end

	epdc_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid),
		.operation(operation), .sample(sample), .last_sample(last_sample),
		.rate(rate_q), .rec(rec_f)
	);

	epdc_series u_series (
		.clk(clk), .arst_n(arst_n), .en(en), .rec_in(rec_f), .rec_out(rec_s)
	);

	epdc_back u_back (
		.clk(clk), .arst_n(arst_n), .en(en), .rec(rec_s), .rate(rate_q),
		.out_valid(out_valid), .value(value), .status(status),
		.last_result(last_result)
	);

	a_rem_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		rec_f.ctl.valid && !rec_f.ctl.neg && !rec_f.ctl.under |-> rec_f.rem < LN2_Q30)
		else $error("reduced argument not below ln2");

	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		rec_f.ctl.valid && !rec_f.ctl.neg && !rec_f.ctl.under |-> 64'(rec_f.k) <= K_MAX)
		else $error("exponent shift out of range");

	a_neg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_NEG |-> value == '0)
		else $error("rejected sample with nonzero value");

endmodule

/* dv/exponential_pdf_cdf_unit_test.sv */
// ----------------------------------------------------------------------------
// Exponential PDF/CDF unit testbench
// Streams samples into the unit under several rate settings, with random gaps
// on both channels. A bit-exact model of the density and cumulative
// arithmetic predicts every result, and each output transfer is checked in
// order against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module exponential_pdf_cdf_unit_test;
	import epdc_pkg::*;

	typedef struct {
		logic              op;
		logic [DATA_W-1:0] x;
		logic              last;
	} sample_t;

	typedef struct {
		logic [DATA_W-1:0] value;
		logic              status;
		logic              last;
	} answer_t;

	localparam int CYCLE_LIMIT = 400000;

	logic              clk;
	logic              arst_n;
	logic              rate_wr_en;
	logic [DATA_W-1:0] rate_wr_data;
	logic              in_valid;
	logic              in_stall;
	logic              operation;
	logic [DATA_W-1:0] sample;
	logic              last_sample;
	logic              out_valid;
	logic              out_stall;
	logic [DATA_W-1:0] value;
	logic              status;
	logic              last_result;

	sample_t pending_samples[$];
	answer_t expected_answers[$];
	logic [63:0] rate_q = 64'd1 << FRAC_BITS;
	int errors = 0;
	int checked = 0;
	int cycles = 0;
	int pdf_seen = 0;
	int cdf_seen = 0;
	int neg_seen = 0;
	bit calm = 0;

	exponential_pdf_cdf_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.rate_wr_en(rate_wr_en), .rate_wr_data(rate_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .sample(sample), .last_sample(last_sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.value(value), .status(status), .last_result(last_result)
	);

	function automatic logic [63:0] rounded_shift(logic [63:0] v, int s);
		if (s >= 63) return 64'd0;
		if (s == 0) return v;
		return (v + (64'd1 << (s - 1))) >> s;
	endfunction

	function automatic answer_t exp_dist_eval(sample_t s);
		answer_t a;
		logic [63:0] p, t, k, r, term, e, ex;
		a.last = s.last;
		a.status = STATUS_OK;
		a.value = '0;
		if (s.x[DATA_W-1]) begin
			a.status = STATUS_NEG;
			return a;
		end
		p = rate_q * {32'd0, s.x};
		if ((p >> (2 * FRAC_BITS)) >= 64) begin
			a.value = (s.op == OP_CDF) ? DATA_W'(1 << FRAC_BITS) : '0;
			return a;
		end
		t = (2 * FRAC_BITS >= EXP_FB) ? p >> (2 * FRAC_BITS - EXP_FB)
			: p << (EXP_FB - 2 * FRAC_BITS);
		k = t / 64'(LN2_Q30);
		r = t - k * 64'(LN2_Q30);
		term = 64'd1 << EXP_FB;
		e = term;
		for (int n = 1; n <= TERMS; n++) begin
			term = ((term * r) >> EXP_FB) / n;
			if (n % 2) e = e - term;
			else e = e + term;
		end
		if (s.op == OP_PDF) begin
			p = rounded_shift(rate_q * e, EXP_FB + int'(k));
			a.value = (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
		end else begin
			ex = rounded_shift(e, EXP_FB - FRAC_BITS + int'(k));
			a.value = (ex >= (64'd1 << FRAC_BITS)) ? '0
				: DATA_W'((64'd1 << FRAC_BITS) - ex);
		end
		return a;
	endfunction

	function automatic logic [DATA_W-1:0] random_x();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return DATA_W'($urandom_range(0, 16));
			2, 3: return DATA_W'($urandom_range(0, 32'h0004_0000));
			4: return DATA_W'($urandom_range(0, 32'h0040_0000));
			5: return {1'b0, 31'($urandom())};
			6: return 32'h8000_0000 | $urandom();
			default: return DATA_W'($urandom_range(0, 32'h0010_0000));
		endcase
	endfunction

	task automatic queue_sample(logic op, logic [DATA_W-1:0] x, logic last);
		sample_t s;
		s.op = op;
		s.x = x;
		s.last = last;
		pending_samples.push_back(s);
	endtask

	task automatic set_rate(logic [DATA_W-1:0] r);
		wait (pending_samples.size() == 0 && !in_valid && expected_answers.size() == 0);
		repeat (LATENCY + 4) @(posedge clk);
		rate_wr_en <= 1'b1;
		rate_wr_data <= r;
		@(posedge clk);
		rate_wr_en <= 1'b0;
		rate_q = {32'd0, r};
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout at %0t with %0d results outstanding.", $time,
				expected_answers.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			operation <= 1'b0;
			sample <= '0;
			last_sample <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				sample_t s;
				s.op = operation;
				s.x = sample;
				s.last = last_sample;
				expected_answers.push_back(exp_dist_eval(s));
			end
			if (!in_valid || !in_stall) begin
				if (pending_samples.size() > 0 && (calm || $urandom_range(0, 99) >= 32)) begin
					sample_t s;
					s = pending_samples.pop_front();
					in_valid <= 1'b1;
					operation <= s.op;
					sample <= s.x;
					last_sample <= s.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_answers.size() == 0) begin
					$display("%0t: unexpected transfer, value %h", $time, value);
					errors <= errors + 1;
				end else begin
					answer_t a;
					a = expected_answers.pop_front();
					checked <= checked + 1;
					if (a.status == STATUS_NEG) neg_seen <= neg_seen + 1;
					if (value !== a.value || status !== a.status || last_result !== a.last) begin
						$display("%0t: mismatch, expected value %h status %b last %b, got %h %b %b",
							$time, a.value, a.status, a.last, value, status, last_result);
						errors <= errors + 1;
					end
				end
			end
			out_stall <= !calm && ($urandom_range(0, 99) < 32);
		end
	end

	initial begin
		logic [DATA_W-1:0] rates[6];
		logic [DATA_W-1:0] edge_x[8];
		rates = '{32'd1, 32'hFFFF_FFFF, 32'h0000_8000, 32'h0004_0000, 32'h0100_0000,
			32'h0001_8000};
		edge_x = '{32'd0, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
			32'h0001_0000, 32'h0000_B172, 32'h0040_0000};
		arst_n = 1'b0;
		rate_wr_en = 1'b0;
		rate_wr_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		foreach (edge_x[i]) begin
			queue_sample(OP_PDF, edge_x[i], i[0]);
			queue_sample(OP_CDF, edge_x[i], !i[0]);
		end
		for (int ph = 0; ph < 7; ph++) begin
			if (ph > 0) set_rate(ph == 6 ? $urandom() : rates[ph - 1]);
			calm = (ph == 3);
			if (ph == 1 || ph == 2) begin
				foreach (edge_x[i]) queue_sample(OP_PDF, edge_x[i], 1'b0);
				queue_sample(OP_CDF, 32'h0000_0001, 1'b1);
			end
			for (int i = 0; i < 215; i++) begin
				logic op;
				op = $urandom_range(0, 1);
				if (op == OP_PDF) pdf_seen++;
				else cdf_seen++;
				queue_sample(op, random_x(), $urandom_range(0, 1));
			end
		end
		wait (pending_samples.size() == 0 && !in_valid && expected_answers.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		$display("Checked %0d results over seven rate settings (%0d negative samples).",
			checked, neg_seen);
		$display("Random mix: %0d density and %0d cumulative requests.", pdf_seen, cdf_seen);
		if (errors == 0 && expected_answers.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
